// File: rtl/core/mpp_pkg.sv
// ----------------------------------------------------------------------------
// Monitor packet parser package
// Framing phases, protocol type codes and divide-by-three constants.
// ----------------------------------------------------------------------------
package mpp_pkg;

    // framing phase of the parser
    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_HEAD  = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    // protocol type codes
    localparam logic [4:0] ECG_TYPE    = 5'd8;
    localparam logic [7:0] PAR_TYPE_LO = 8'h09;
    localparam logic [7:0] PAR_TYPE_HI = 8'h1A;

    // ecg packets carry seven data bytes, indexes 0 to 6
    localparam logic [2:0] ECG_LAST_INDEX = 3'd6;

    // sum of three samples and its magnitude
    localparam int ACC_W = 18;
    localparam int MAG_W = 17;
    localparam int Q_W   = 16;

    // floor(n / 3) = (n * ceil(2^18 / 3)) >> 18, exact for n below 2^17
    localparam logic [MAG_W-1:0] DIV3_RECIP = 17'h15556;
    localparam int               DIV3_SHIFT = 18;

endpackage

// File: rtl/core/monitor_packet_parser.sv
// ----------------------------------------------------------------------------
// Monitor packet parser
// Reassembles ecg and parameter packets from a received byte stream, checks
// them and emits one result per good packet.
// A result is valid in the cycle after its check byte is transferred.
// Throughput: one byte per cycle; input stalls only while a result is held.
// ECG samples are summed as their byte pairs arrive, and the divide by three
// is a reciprocal multiply done on the last data byte.
// Reset: rst_n clears the framing state and the result valid at once.
// ----------------------------------------------------------------------------
module monitor_packet_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  packet_type,
    output logic signed [15:0] sample_value
);

    // control state
    mpp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      cur_type_reg, cur_type_next;
    logic [7:0]      high_bits_reg, high_bits_next;
    logic [2:0]      byte_idx_reg, byte_idx_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    logic [7:0]                       hold_reg, hold_next;
    logic signed [mpp_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [mpp_pkg::Q_W-1:0]          qmag_reg, qmag_next;
    logic                             neg_reg, neg_next;
    logic [4:0]                       packet_type_reg, packet_type_next;
    logic [15:0]                      sample_value_reg, sample_value_next;

    // decode of the incoming byte
    logic                        take;
    mpp_pkg::phase_t             eff_phase;
    logic                        type_ok;
    logic                        is_ecg;
    logic [7:0]                  restored;
    logic [15:0]                 sample;
    logic [mpp_pkg::ACC_W-1:0]   acc_abs;
    logic [mpp_pkg::MAG_W-1:0]   acc_mag;
    logic [2*mpp_pkg::MAG_W-1:0] product;
    logic                        result_hit;
    logic [4:0]                  result_type;
    logic [15:0]                 result_value;

    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign eff_phase = rx_byte[7] ? phase_reg : mpp_pkg::PH_TYPE;
    assign type_ok   = (rx_byte == {3'b000, mpp_pkg::ECG_TYPE})
                    || (rx_byte >= mpp_pkg::PAR_TYPE_LO && rx_byte <= mpp_pkg::PAR_TYPE_HI);
    assign is_ecg    = (cur_type_reg == mpp_pkg::ECG_TYPE);

    // data byte with bit 7 taken from the head byte
    assign restored = {high_bits_reg[is_ecg ? byte_idx_reg : 3'd0], rx_byte[6:0]};
    assign sample   = {hold_reg, restored};

    // magnitude of the ecg sum divided by three
    assign acc_abs = acc_reg[mpp_pkg::ACC_W-1] ? mpp_pkg::ACC_W'(-acc_reg) : acc_reg;
    assign acc_mag = acc_abs[mpp_pkg::MAG_W-1:0];
    assign product = acc_mag * mpp_pkg::DIV3_RECIP;

    // next framing phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (eff_phase)
                mpp_pkg::PH_TYPE:
                begin
                    phase_next = type_ok ? mpp_pkg::PH_HEAD : mpp_pkg::PH_TYPE;
                end
                mpp_pkg::PH_HEAD:
                begin
                    phase_next = mpp_pkg::PH_DATA;
                end
                mpp_pkg::PH_DATA:
                begin
                    if (!is_ecg || byte_idx_reg == mpp_pkg::ECG_LAST_INDEX)
                        phase_next = mpp_pkg::PH_CHECK;
                    else
                        phase_next = mpp_pkg::PH_DATA;
                end
                mpp_pkg::PH_CHECK:
                begin
                    phase_next = mpp_pkg::PH_TYPE;
                end
                default:
                begin
                    phase_next = mpp_pkg::PH_TYPE;
                end
            endcase
        end
    end

    // per-phase register updates and the packet check
    always_comb
    begin
        cur_type_next  = cur_type_reg;
        high_bits_next = high_bits_reg;
        byte_idx_next  = byte_idx_reg;
        hold_next      = hold_reg;
        acc_next       = acc_reg;
        qmag_next      = qmag_reg;
        neg_next       = neg_reg;
        result_hit     = 1'b0;
        result_type    = cur_type_reg;
        result_value   = {8'h00, hold_reg};
        if (take)
        begin
            case (eff_phase)
                mpp_pkg::PH_TYPE:
                begin
                    if (type_ok)
                    begin
                        cur_type_next  = rx_byte[4:0];
                        high_bits_next = 8'h00;
                    end
                end
                mpp_pkg::PH_HEAD:
                begin
                    high_bits_next = rx_byte;
                    byte_idx_next  = 3'd0;
                    acc_next       = '0;
                end
                mpp_pkg::PH_DATA:
                begin
                    if (is_ecg)
                    begin
                        byte_idx_next = byte_idx_reg + 3'd1;
                        // even bytes are sample high halves, odd bytes close a sample
                        if (!byte_idx_reg[0])
                            hold_next = restored;
                        else
                            acc_next = acc_reg + mpp_pkg::ACC_W'(signed'(sample));
                        // sum is final by the last data byte
                        if (byte_idx_reg == mpp_pkg::ECG_LAST_INDEX)
                        begin
                            qmag_next = product[mpp_pkg::DIV3_SHIFT +: mpp_pkg::Q_W];
                            neg_next  = acc_reg[mpp_pkg::ACC_W-1];
                        end
                    end
                    else
                    begin
                        hold_next = restored;
                    end
                end
                mpp_pkg::PH_CHECK:
                begin
                    if (is_ecg)
                    begin
                        result_hit   = (acc_reg[7:0] == {1'b0, rx_byte[6:0]});
                        result_value = neg_reg ? 16'(-qmag_reg) : qmag_reg;
                    end
                    else
                    begin
                        result_hit   = (hold_reg[6:0] == rx_byte[6:0]);
                        result_value = {8'h00, hold_reg};
                    end
                end
                default:
                begin
                    result_hit = 1'b0;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        packet_type_next  = packet_type_reg;
        sample_value_next = sample_value_reg;
        if (take && result_hit)
        begin
            out_valid_next    = 1'b1;
            packet_type_next  = result_type;
            sample_value_next = result_value;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mpp_pkg::PH_TYPE;
            cur_type_reg  <= 5'd0;
            high_bits_reg <= 8'h00;
            byte_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cur_type_reg  <= cur_type_next;
            high_bits_reg <= high_bits_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg         <= hold_next;
        acc_reg          <= acc_next;
        qmag_reg         <= qmag_next;
        neg_reg          <= neg_next;
        packet_type_reg  <= packet_type_next;
        sample_value_reg <= sample_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign packet_type  = packet_type_reg;
    assign sample_value = sample_value_reg;

endmodule

// File: bench/monitor_packet_parser_tb.sv
// ----------------------------------------------------------------------------
// Monitor packet parser testbench
// Streams framed ecg and parameter packets, broken frames and line noise into
// the parser under random valid/ready idling. A framing tracker in the bench
// predicts each good packet's result, and every output transfer is compared
// against the oldest prediction.
// ----------------------------------------------------------------------------
module monitor_packet_parser_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0]         ptype;
        logic signed [15:0] value;
    } packet_result_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [4:0]         packet_type;
    logic signed [15:0] sample_value;

    // idling percentages and the long receiver hold-off
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    logic   holding = 1'b0;
    event   hold_start;

    int          failures = 0;
    int          reported = 0;
    int unsigned cycles_run = 0;

    packet_result_t packet_results_q [$];

    // framing tracker state
    mpp_pkg::phase_t trk_phase;
    logic [4:0]      trk_type;
    logic [7:0]      trk_head;
    logic [2:0]      trk_index;
    logic [7:0]      trk_data [7];

    monitor_packet_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_type  (packet_type),
        .sample_value (sample_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run time limit
    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("monitor_packet_parser verification failed");
            $finish;
        end
    end

    // receiver ready, random idling unless held off
    always @(posedge clk)
    begin
        out_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted in cycles
    initial
    begin
        forever
        begin
            @(hold_start);
            holding <= 1'b1;
            for (int n = 0; n < HOLD_CYCLES; n++)
                @(posedge clk);
            holding <= 1'b0;
        end
    end

    // compare each output transfer with the oldest predicted result
    always @(posedge clk)
    begin : check_results
        packet_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (packet_results_q.size() == 0)
            begin
                failures++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected result: type %0d value %0d",
                             packet_type, sample_value);
                end
            end
            else
            begin
                want = packet_results_q.pop_front();
                if (packet_type !== want.ptype || sample_value !== want.value)
                begin
                    failures++;
                    if (reported < MAX_REPORTS)
                    begin
                        reported++;
                        $display(
                            "mismatch: expected type %0d value %0d, got type %0d value %0d",
                            want.ptype, want.value, packet_type, sample_value);
                    end
                end
            end
        end
    end

    function automatic bit is_param_type(input logic [7:0] t);
        return t >= mpp_pkg::PAR_TYPE_LO && t <= mpp_pkg::PAR_TYPE_HI;
    endfunction

    task automatic reset_tracker();
        trk_phase = mpp_pkg::PH_TYPE;
        trk_type  = 5'd0;
        trk_head  = 8'h00;
        trk_index = 3'd0;
        for (int i = 0; i < 7; i++)
            trk_data[i] = 8'h00;
    endtask

    // advance the framing tracker by one accepted byte
    task automatic track_framing(input logic [7:0] b);
        int             total;
        int             quot;
        packet_result_t res;
        if (!b[7])
            trk_phase = mpp_pkg::PH_TYPE;
        case (trk_phase)
            mpp_pkg::PH_TYPE:
            begin
                if (b == {3'b000, mpp_pkg::ECG_TYPE} || is_param_type(b))
                begin
                    trk_type  = b[4:0];
                    trk_head  = 8'h00;
                    trk_phase = mpp_pkg::PH_HEAD;
                end
            end
            mpp_pkg::PH_HEAD:
            begin
                trk_head  = b;
                trk_index = 3'd0;
                trk_phase = mpp_pkg::PH_DATA;
            end
            mpp_pkg::PH_DATA:
            begin
                if (trk_type == mpp_pkg::ECG_TYPE)
                begin
                    trk_data[trk_index] = {trk_head[trk_index], b[6:0]};
                    if (trk_index == mpp_pkg::ECG_LAST_INDEX)
                        trk_phase = mpp_pkg::PH_CHECK;
                    trk_index = trk_index + 3'd1;
                end
                else
                begin
                    trk_data[0] = {trk_head[0], b[6:0]};
                    trk_phase   = mpp_pkg::PH_CHECK;
                end
            end
            default:
            begin
                if (trk_type == mpp_pkg::ECG_TYPE)
                begin
                    total = int'($signed({trk_data[0], trk_data[1]}))
                          + int'($signed({trk_data[2], trk_data[3]}))
                          + int'($signed({trk_data[4], trk_data[5]}));
                    if (total[7:0] == {1'b0, b[6:0]})
                    begin
                        quot      = total / 3;
                        res.ptype = mpp_pkg::ECG_TYPE;
                        res.value = quot[15:0];
                        packet_results_q.push_back(res);
                    end
                end
                else if (trk_data[0][6:0] == b[6:0])
                begin
                    res.ptype = trk_type;
                    res.value = {8'h00, trk_data[0]};
                    packet_results_q.push_back(res);
                end
                trk_phase = mpp_pkg::PH_TYPE;
            end
        endcase
    endtask

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        track_framing(b);
    endtask

    // frame type, head, data bytes and check byte; only the first upto bytes go out
    task automatic send_frame(input logic [4:0] kind, input logic [55:0] raw,
                              input logic [7:0] chk, input int upto, output int sent);
        logic [7:0] frame [$];
        logic [7:0] head;
        int         ndata;
        ndata = (kind == mpp_pkg::ECG_TYPE) ? 7 : 1;
        head  = {1'b1, 7'($urandom)};
        for (int i = 0; i < ndata; i++)
            head[i] = raw[8*i+7];
        frame.push_back({3'b000, kind});
        frame.push_back(head);
        for (int i = 0; i < ndata; i++)
            frame.push_back({1'b1, raw[8*i +: 7]});
        frame.push_back(chk);
        sent = 0;
        for (int i = 0; i < frame.size() && i < upto; i++)
        begin
            send_byte(frame[i]);
            sent++;
        end
    endtask

    // ecg frame from three samples; a good one gets sum bit 7 cleared and a matching check
    task automatic send_ecg(input logic [15:0] s0, input logic [15:0] s1,
                            input logic [15:0] s2, input bit good, input int upto,
                            output int sent);
        logic [55:0] raw;
        logic [7:0]  chk;
        int          total;
        total = int'($signed(s0)) + int'($signed(s1)) + int'($signed(s2));
        if (good && total[7])
        begin
            s0[7] = ~s0[7];
            total = int'($signed(s0)) + int'($signed(s1)) + int'($signed(s2));
        end
        raw = {8'($urandom), s2[7:0], s2[15:8], s1[7:0], s1[15:8], s0[7:0], s0[15:8]};
        chk = good ? {1'b1, total[6:0]} : {1'b1, 7'($urandom)};
        send_frame(mpp_pkg::ECG_TYPE, raw, chk, upto, sent);
    endtask

    // parameter frame; a bad one gets a check that differs in at least one bit
    task automatic send_param(input logic [4:0] kind, input logic [7:0] value,
                              input bit good, input int upto, output int sent);
        logic [6:0] flip;
        flip = 7'($urandom_range(127, 1));
        send_frame(kind, {48'h0, value},
                   good ? {1'b1, value[6:0]} : {1'b1, value[6:0] ^ flip}, upto, sent);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [4:0] pick_param_type();
        return 5'($urandom_range(mpp_pkg::PAR_TYPE_HI, mpp_pkg::PAR_TYPE_LO));
    endfunction

    // bytes with bit 7 set while idle, and type codes outside the protocol
    task automatic test_ignored_bytes();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h1B);
    endtask

    // parameter channels at both ends, values at both ends
    task automatic test_param_extremes();
        int sent;
        send_param(5'(mpp_pkg::PAR_TYPE_LO), 8'hFF, 1'b1, 4, sent);
        send_param(5'(mpp_pkg::PAR_TYPE_HI), 8'h00, 1'b1, 4, sent);
    endtask

    // most negative samples give the most negative average
    task automatic test_ecg_extreme();
        int sent;
        send_ecg(16'h8000, 16'h8000, 16'h8000, 1'b1, 10, sent);
    endtask

    // packet cut short by a new type byte, then a failing check
    task automatic test_abandon_and_bad_check();
        int sent;
        send_param(5'h11, 8'h55, 1'b1, 2, sent);
        send_param(5'h0A, 8'h05, 1'b0, 4, sent);
    endtask

    // one random packet, well formed most of the time; returns packet bytes sent
    task automatic send_random_packet(output int sent);
        int  pick;
        bit  is_ecg;
        int  len;
        pick   = $urandom_range(99);
        is_ecg = 1'($urandom_range(1));
        len    = is_ecg ? 10 : 4;
        sent   = 0;
        if (pick < 35)
            send_ecg(pick_sample(), pick_sample(), pick_sample(), 1'b1, len, sent);
        else if (pick < 75)
            send_param(pick_param_type(), 8'($urandom), 1'b1, 4, sent);
        else if (pick < 93)
        begin
            // bad check or truncated frame
            if (pick >= 85)
                len = $urandom_range(len - 1, 1);
            if (is_ecg)
                send_ecg(pick_sample(), pick_sample(), pick_sample(), pick >= 85, len, sent);
            else
                send_param(pick_param_type(), 8'($urandom), pick >= 85, len, sent);
        end
        else
        begin
            // line noise, not counted
            repeat ($urandom_range(3, 1))
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int nbytes);
        int total;
        int sent;
        total = 0;
        while (total < nbytes)
        begin
            send_random_packet(sent);
            total += sent;
        end
    endtask

    // receiver holds off while good packets keep coming, so the input stalls
    task automatic test_output_backpressure();
        int sent;
        -> hold_start;
        repeat (12)
            send_param(pick_param_type(), 8'($urandom), 1'b1, 4, sent);
    endtask

    initial
    begin
        reset_tracker();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 76;
        test_ignored_bytes();
        test_param_extremes();
        test_ecg_extreme();
        test_abandon_and_bad_check();
        test_random_traffic(170);
        test_output_backpressure();

        send_idle_pct = 76;
        recv_idle_pct = 14;
        test_random_traffic(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(170);

        // drain
        in_valid <= 1'b0;
        while (packet_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (packet_results_q.size() != 0)
        begin
            failures++;
            $display("%0d results never arrived", packet_results_q.size());
        end
        if (failures == 0)
            $display("monitor_packet_parser verification clean");
        else
            $display("monitor_packet_parser verification failed");
        $finish;
    end

endmodule
